### sv/triangle_tangent_basis_core_assert.svh
// Assertion macros shared by the triangle tangent basis RTL.
`ifndef TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH

// The condition must never hold outside reset.
`define TTB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define TTB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define TTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ttb_pkg.sv
// Shared types and constants of the triangle tangent basis core.
`default_nettype none
package ttb_pkg;

    localparam int THR_W    = 16;
    localparam int SCL_W    = 31;
    localparam int SUM_W    = 64;
    localparam int CORNER_W = 2;

    localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd2;
    localparam logic [3:0] CROSS_STEPS = 4'd12;
    localparam logic [3:0] VEC_STEPS   = 4'd6;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CROSS,
        B_NORM_T,
        B_WAIT_T,
        B_NORM_B,
        B_WAIT_B,
        B_PUSH
    } t_back_state;

    typedef enum logic [3:0] {
        N_IDLE,
        N_MAG,
        N_THR,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } t_norm_state;

    function automatic logic [1:0] corner_edge_a(input logic [CORNER_W-1:0] k);
        return (k == LAST_CORNER) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] corner_edge_b(input logic [CORNER_W-1:0] k);
        return (k == 2'd0) ? 2'd1 : 2'd2;
    endfunction

endpackage
`default_nettype wire

### sv/ttb_fifo.sv
// Small register queue used between the front, the back and the result port.
`default_nettype none
`include "triangle_tangent_basis_core_assert.svh"
module ttb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `TTB_ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CNT_W'(DEPTH), "Queue count above depth.")
    `TTB_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push_ok && !pop_ok, r_cnt == $past(r_cnt) + 1'b1, "Queue count did not grow.")

endmodule
`default_nettype wire

### sv/ttb_front.sv
// Front end: holds the first two wedges and forms the edge job on the third.
`default_nettype none
module ttb_front #(
    parameter int POS_WIDTH = 32,
    parameter int UV_WIDTH  = 24,
    parameter int JOB_W     = 447
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic signed [POS_WIDTH-1:0] i_pos_x,
    input  wire logic signed [POS_WIDTH-1:0] i_pos_y,
    input  wire logic signed [POS_WIDTH-1:0] i_pos_z,
    input  wire logic signed [UV_WIDTH-1:0]  i_tex_u,
    input  wire logic signed [UV_WIDTH-1:0]  i_tex_v,
    input  wire logic                        i_first_corner,
    output logic                             o_job_push,
    output logic [JOB_W-1:0]                 o_job_data,
    input  wire logic                        i_job_full
);

    localparam int PRE = (POS_WIDTH + UV_WIDTH > 60) ? (POS_WIDTH + UV_WIDTH - 60) : 0;
    localparam int EPW = POS_WIDTH + 1 - PRE;
    localparam int EUW = UV_WIDTH + 1;

    logic        [1:0]           r_cnt;
    logic signed [POS_WIDTH-1:0] r_pos [2][3];
    logic signed [UV_WIDTH-1:0]  r_u [2];
    logic signed [UV_WIDTH-1:0]  r_v [2];

    logic [1:0]                  slot;
    logic                        accept;
    logic                        third;
    logic signed [POS_WIDTH-1:0] in_pos [3];
    logic signed [POS_WIDTH-1:0] pa [3][3];
    logic signed [UV_WIDTH-1:0]  ua [3];
    logic signed [UV_WIDTH-1:0]  va [3];
    logic signed [POS_WIDTH:0]   dpos [3][3];
    logic signed [POS_WIDTH:0]   spos [3][3];

    assign o_full     = i_job_full;
    assign accept     = i_push && !o_full;
    assign slot       = i_first_corner ? 2'd0 : r_cnt;
    assign third      = (slot == 2'd2);
    assign o_job_push = accept && third;
    assign in_pos[0]  = i_pos_x;
    assign in_pos[1]  = i_pos_y;
    assign in_pos[2]  = i_pos_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa[0][i] = r_pos[0][i];
            pa[1][i] = r_pos[1][i];
            pa[2][i] = in_pos[i];
        end
        ua[0] = r_u[0];
        ua[1] = r_u[1];
        ua[2] = i_tex_u;
        va[0] = r_v[0];
        va[1] = r_v[1];
        va[2] = i_tex_v;
        o_job_data = '0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                dpos[k][i] = {pa[(k == 0) ? 1 : 2][i][POS_WIDTH-1], pa[(k == 0) ? 1 : 2][i]}
                           - {pa[(k == 2) ? 1 : 0][i][POS_WIDTH-1], pa[(k == 2) ? 1 : 0][i]};
                spos[k][i] = dpos[k][i] >>> PRE;
                o_job_data[(k*3+i)*EPW +: EPW] = spos[k][i][EPW-1:0];
            end
            o_job_data[9*EPW + k*EUW +: EUW] =
                {ua[(k == 0) ? 1 : 2][UV_WIDTH-1], ua[(k == 0) ? 1 : 2]}
              - {ua[(k == 2) ? 1 : 0][UV_WIDTH-1], ua[(k == 2) ? 1 : 0]};
            o_job_data[9*EPW + 3*EUW + k*EUW +: EUW] =
                {va[(k == 0) ? 1 : 2][UV_WIDTH-1], va[(k == 0) ? 1 : 2]}
              - {va[(k == 2) ? 1 : 0][UV_WIDTH-1], va[(k == 2) ? 1 : 0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= third ? 2'd0 : slot + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !third) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[slot[0]][i] <= in_pos[i];
            end
            r_u[slot[0]] <= i_tex_u;
            r_v[slot[0]] <= i_tex_v;
        end
    end

endmodule
`default_nettype wire

### sv/ttb_norm.sv
// Shared iterative unit that negates and normalizes one vector to Q1.F.
`default_nettype none
`include "triangle_tangent_basis_core_assert.svh"
module ttb_norm
    import ttb_pkg::*;
#(
    parameter int CW = 59,
    parameter int F  = 14
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [CW-1:0] i_vec [3],
    input  wire logic [THR_W-1:0]     i_thr,
    output logic                      o_done,
    output logic signed [F+1:0]       o_res [3]
);

    localparam int XW = (CW > SCL_W) ? CW : SCL_W;
    localparam int DW = SCL_W + 1 + F;
    localparam int JW = $clog2(F + 1);
    localparam int SQW = 2 * SCL_W;
    localparam logic [F:0] OUT_ONE = {1'b1, {F{1'b0}}};

    t_norm_state          r_state;
    t_norm_state          n_state;
    logic                 r_neg [3];
    logic [XW-1:0]        r_mag [3];
    logic [1:0]           r_cnt;
    logic [SQW-1:0]       r_sq;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     r_root;
    logic [SUM_W-1:0]     r_bit;
    logic [1:0]           r_ci;
    logic [JW-1:0]        r_j;
    logic [DW-1:0]        r_div;
    logic [F:0]           r_quo;
    logic signed [F+1:0]  r_res [3];

    logic [CW-1:0]        absv [3];
    logic [XW-1:0]        mx01;
    logic [XW-1:0]        mx;
    logic                 is_zero;
    logic                 is_small;
    logic                 scaled;
    logic [SCL_W-1:0]     sq_op;
    logic [SUM_W-1:0]     n_sum;
    logic                 thr_low;
    logic [SUM_W-1:0]     root_try;
    logic [SCL_W:0]       q;
    logic [SCL_W-1:0]     div_mag;
    logic [DW-1:0]        q_shift;
    logic                 q_ge;
    logic [F:0]           quo_n;
    logic [F:0]           quo_c;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            absv[i] = i_vec[i][CW-1] ? CW'(-i_vec[i]) : CW'(i_vec[i]);
        end
        mx01     = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
        mx       = (mx01 > r_mag[2]) ? mx01 : r_mag[2];
        is_zero  = (mx == '0);
        is_small = ((mx >> SCL_W) == '0);
        scaled   = is_small && mx[SCL_W-1];
        case (r_cnt)
            2'd0:    sq_op = r_mag[0][SCL_W-1:0];
            2'd1:    sq_op = r_mag[1][SCL_W-1:0];
            default: sq_op = r_mag[2][SCL_W-1:0];
        endcase
        n_sum    = r_sum + SUM_W'(r_sq);
        thr_low  = (n_sum < SUM_W'(i_thr));
        root_try = r_root + r_bit;
        q        = r_root[SCL_W:0];
        case (r_ci)
            2'd0:    div_mag = r_mag[0][SCL_W-1:0];
            2'd1:    div_mag = r_mag[1][SCL_W-1:0];
            default: div_mag = r_mag[2][SCL_W-1:0];
        endcase
        q_shift = DW'(q) << r_j;
        q_ge    = (r_div >= q_shift);
        quo_n   = {r_quo[F-1:0], q_ge};
        quo_c   = (quo_n > OUT_ONE) ? OUT_ONE : quo_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    n_state = N_MAG;
                end
            end
            N_MAG: begin
                if (is_zero) begin
                    n_state = N_DONE;
                end else if (is_small) begin
                    n_state = N_THR;
                end else begin
                    n_state = N_SHIFT;
                end
            end
            N_THR: begin
                if (r_cnt == 2'd3) begin
                    n_state = thr_low ? N_DONE : N_SHIFT;
                end
            end
            N_SHIFT: begin
                if (scaled) begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                if (r_cnt == 2'd3) begin
                    n_state = N_SQRT;
                end
            end
            N_SQRT: begin
                if (r_bit == SUM_W'(1)) begin
                    n_state = N_DLOAD;
                end
            end
            N_DLOAD: begin
                n_state = N_DIV;
            end
            N_DIV: begin
                if (r_j == '0) begin
                    n_state = (r_ci == 2'd2) ? N_DONE : N_DLOAD;
                end
            end
            N_DONE: begin
                o_done  = 1'b1;
                n_state = N_IDLE;
            end
            default: begin
                n_state = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= i_vec[i][CW-1];
                        r_mag[i] <= XW'(absv[i]);
                    end
                end
            end
            N_MAG: begin
                r_cnt <= 2'd0;
                r_sum <= '0;
                r_ci  <= 2'd0;
                if (is_zero) begin
                    for (int i = 0; i < 3; i++) begin
                        r_res[i] <= '0;
                    end
                end
            end
            N_THR: begin
                r_sq  <= SQW'(sq_op) * SQW'(sq_op);
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_sum <= '0;
                    if (thr_low) begin
                        for (int i = 0; i < 3; i++) begin
                            r_res[i] <= '0;
                        end
                    end
                end else if (r_cnt != 2'd0) begin
                    r_sum <= n_sum;
                end
            end
            N_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if ((mx >> (SCL_W + 4)) != '0) begin
                        r_mag[i] <= r_mag[i] >> 4;
                    end else if (!is_small) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else if ((mx >> (SCL_W - 5)) == '0) begin
                        r_mag[i] <= r_mag[i] << 4;
                    end else if (!mx[SCL_W-1]) begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
            end
            N_SQ: begin
                r_sq  <= SQW'(sq_op) * SQW'(sq_op);
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt != 2'd0) begin
                    r_sum <= n_sum;
                end
                r_root <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
            end
            N_SQRT: begin
                if (r_sum >= root_try) begin
                    r_sum  <= r_sum - root_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            N_DLOAD: begin
                r_div <= (DW'(div_mag) << F) + DW'(q >> 1);
                r_j   <= JW'(F);
                r_quo <= '0;
            end
            N_DIV: begin
                if (q_ge) begin
                    r_div <= r_div - q_shift;
                end
                r_quo <= quo_n;
                r_j   <= r_j - 1'b1;
                if (r_j == '0) begin
                    r_res[r_ci] <= r_neg[r_ci] ? $signed({1'b0, quo_c})
                                               : -$signed({1'b0, quo_c});
                    r_ci <= r_ci + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

    `TTB_ASSERT_IMPLIES(a_start_idle, i_clk, i_rst_n, i_start, r_state == N_IDLE, "Normalizer started while busy.")

endmodule
`default_nettype wire

### sv/ttb_back.sv
// Back end: cross terms for each corner and two normalizations per result.
`default_nettype none
`include "triangle_tangent_basis_core_assert.svh"
module ttb_back
    import ttb_pkg::*;
#(
    parameter int POS_WIDTH     = 32,
    parameter int UV_WIDTH      = 24,
    parameter int OUT_FRAC_BITS = 14,
    parameter int JOB_W         = 447,
    parameter int RES_W         = 99
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_empty,
    input  wire logic [JOB_W-1:0] i_job_data,
    output logic                  o_job_pop,
    input  wire logic [THR_W-1:0] i_thr,
    output logic                  o_res_push,
    output logic      [RES_W-1:0] o_res_data,
    input  wire logic             i_res_full
);

    localparam int PRE = (POS_WIDTH + UV_WIDTH > 60) ? (POS_WIDTH + UV_WIDTH - 60) : 0;
    localparam int EPW = POS_WIDTH + 1 - PRE;
    localparam int EUW = UV_WIDTH + 1;
    localparam int PW  = EPW + EUW;
    localparam int CW  = PW + 1;
    localparam int OW  = OUT_FRAC_BITS + 2;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [CORNER_W-1:0]   r_k;
    logic [3:0]            r_step;
    logic [3:0]            r_pstep;
    logic signed [EPW-1:0] r_ep [3][3];
    logic signed [EUW-1:0] r_eu [3];
    logic signed [EUW-1:0] r_ev [3];
    logic signed [PW-1:0]  r_prod;
    logic signed [PW-1:0]  r_acc;
    logic signed [CW-1:0]  r_cross [2][3];
    logic signed [OW-1:0]  r_tan [3];
    logic signed [OW-1:0]  r_btan [3];

    logic                  vsel;
    logic [3:0]            rem;
    logic [1:0]            comp;
    logic                  sel_b;
    logic [1:0]            ka;
    logic [1:0]            kb;
    logic [1:0]            ep_idx;
    logic [1:0]            uv_idx;
    logic signed [EPW-1:0] ep_op;
    logic signed [EUW-1:0] uv_op;
    logic signed [PW-1:0]  n_prod;
    logic                  pvsel;
    logic [3:0]            prem;
    logic [1:0]            pcomp;
    logic signed [CW-1:0]  n_cross;
    logic                  norm_start;
    logic                  norm_done;
    logic signed [CW-1:0]  norm_vec [3];
    logic signed [OW-1:0]  norm_res [3];

    always_comb begin
        vsel   = (r_step >= VEC_STEPS);
        rem    = vsel ? r_step - VEC_STEPS : r_step;
        comp   = rem[2:1];
        sel_b  = vsel ^ rem[0];
        ka     = corner_edge_a(r_k);
        kb     = corner_edge_b(r_k);
        ep_idx = sel_b ? kb : ka;
        uv_idx = sel_b ? ka : kb;
        ep_op  = r_ep[ep_idx][comp];
        uv_op  = vsel ? r_eu[uv_idx] : r_ev[uv_idx];
        n_prod = ep_op * uv_op;
        pvsel  = (r_pstep >= VEC_STEPS);
        prem   = pvsel ? r_pstep - VEC_STEPS : r_pstep;
        pcomp  = prem[2:1];
        n_cross = r_acc - r_prod;
        for (int i = 0; i < 3; i++) begin
            norm_vec[i] = (r_state == B_NORM_B) ? r_cross[1][i] : r_cross[0][i];
        end
    end

    ttb_norm #(
        .CW (CW),
        .F  (OUT_FRAC_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (norm_vec),
        .i_thr   (i_thr),
        .o_done  (norm_done),
        .o_res   (norm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        norm_start = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = B_CROSS;
                end
            end
            B_CROSS: begin
                if (r_step == CROSS_STEPS) begin
                    n_state = B_NORM_T;
                end
            end
            B_NORM_T: begin
                norm_start = 1'b1;
                n_state    = B_WAIT_T;
            end
            B_WAIT_T: begin
                if (norm_done) begin
                    n_state = B_NORM_B;
                end
            end
            B_NORM_B: begin
                norm_start = 1'b1;
                n_state    = B_WAIT_B;
            end
            B_WAIT_B: begin
                if (norm_done) begin
                    n_state = B_PUSH;
                end
            end
            B_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = (r_k == LAST_CORNER) ? B_IDLE : B_CROSS;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_step <= '0;
        end else if (r_state == B_IDLE) begin
            r_k    <= '0;
            r_step <= '0;
        end else if (r_state == B_CROSS) begin
            r_step <= r_step + 4'd1;
        end else if (r_state == B_PUSH && !i_res_full) begin
            r_k    <= r_k + 1'b1;
            r_step <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_ep[k][i] <= i_job_data[(k*3+i)*EPW +: EPW];
                end
                r_eu[k] <= i_job_data[9*EPW + k*EUW +: EUW];
                r_ev[k] <= i_job_data[9*EPW + 3*EUW + k*EUW +: EUW];
            end
        end
        if (r_state == B_CROSS) begin
            if (r_step < CROSS_STEPS) begin
                r_prod  <= n_prod;
                r_pstep <= r_step;
            end
            if (r_step != 4'd0) begin
                if (!prem[0]) begin
                    r_acc <= r_prod;
                end else begin
                    r_cross[pvsel][pcomp] <= n_cross;
                end
            end
        end
        if (norm_done && r_state == B_WAIT_T) begin
            r_tan <= norm_res;
        end
        if (norm_done && r_state == B_WAIT_B) begin
            r_btan <= norm_res;
        end
    end

    assign o_res_data = {r_tan[0], r_tan[1], r_tan[2], r_btan[0], r_btan[1], r_btan[2],
                         r_k, (r_k == LAST_CORNER)};

    `TTB_ASSERT_IMPLIES(a_done_waiting, i_clk, i_rst_n, norm_done, r_state == B_WAIT_T || r_state == B_WAIT_B, "Normalizer finished outside a wait state.")

endmodule
`default_nettype wire

### sv/triangle_tangent_basis_core.sv
// Top level of the per-triangle tangent and bitangent core.
// Wedges enter through a queue-style port: an item is taken at a clock edge with push high
// and full low. The first two wedges of a triangle are held; the third one forms the edge
// vectors and their uv differences and places one job in a two-entry queue. first_corner
// restarts the triangle with the current wedge as corner 0.
// The back end works one job at a time. Per corner it forms six cross terms with one
// multiplier, then runs the shared normalizer twice, for the tangent and the bitangent.
// The square root and the divider in the normalizer retire one bit a cycle.
// Results leave through a two-entry queue: the oldest is on the ports while empty is low and
// is taken at an edge with pop high. A stalled reader fills the result queue, then the job
// queue, and finally raises full on the input side.
// The threshold register is written with i_cfg_we and resets to 1. Reset empties both queues
// and restarts the corner count; held wedges keep no state that matters after reset.
`default_nettype none
module triangle_tangent_basis_core
    import ttb_pkg::*;
#(
    parameter int POS_WIDTH     = 32,
    parameter int UV_WIDTH      = 24,
    parameter int OUT_FRAC_BITS = 14
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic signed [POS_WIDTH-1:0]     i_pos_x,
    input  wire logic signed [POS_WIDTH-1:0]     i_pos_y,
    input  wire logic signed [POS_WIDTH-1:0]     i_pos_z,
    input  wire logic signed [UV_WIDTH-1:0]      i_tex_u,
    input  wire logic signed [UV_WIDTH-1:0]      i_tex_v,
    input  wire logic                            i_first_corner,
    input  wire logic                            i_cfg_we,
    input  wire logic [THR_W-1:0]                i_cfg_wdata,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic signed [OUT_FRAC_BITS+1:0]      o_tangent_x,
    output logic signed [OUT_FRAC_BITS+1:0]      o_tangent_y,
    output logic signed [OUT_FRAC_BITS+1:0]      o_tangent_z,
    output logic signed [OUT_FRAC_BITS+1:0]      o_bitangent_x,
    output logic signed [OUT_FRAC_BITS+1:0]      o_bitangent_y,
    output logic signed [OUT_FRAC_BITS+1:0]      o_bitangent_z,
    output logic [CORNER_W-1:0]                  o_corner,
    output logic                                 o_last
);

    localparam int PRE   = (POS_WIDTH + UV_WIDTH > 60) ? (POS_WIDTH + UV_WIDTH - 60) : 0;
    localparam int EPW   = POS_WIDTH + 1 - PRE;
    localparam int EUW   = UV_WIDTH + 1;
    localparam int JOB_W = 9 * EPW + 6 * EUW;
    localparam int OW    = OUT_FRAC_BITS + 2;
    localparam int RES_W = 6 * OW + CORNER_W + 1;

    logic [THR_W-1:0] r_thr;
    logic             job_push;
    logic [JOB_W-1:0] job_wdata;
    logic             job_full;
    logic             job_pop;
    logic [JOB_W-1:0] job_rdata;
    logic             job_empty;
    logic             res_push;
    logic [RES_W-1:0] res_wdata;
    logic             res_full;
    logic [RES_W-1:0] res_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    ttb_front #(
        .POS_WIDTH (POS_WIDTH),
        .UV_WIDTH  (UV_WIDTH),
        .JOB_W     (JOB_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_tex_u        (i_tex_u),
        .i_tex_v        (i_tex_v),
        .i_first_corner (i_first_corner),
        .o_job_push     (job_push),
        .o_job_data     (job_wdata),
        .i_job_full     (job_full)
    );

    ttb_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_wdata),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_rdata),
        .o_empty (job_empty)
    );

    ttb_back #(
        .POS_WIDTH     (POS_WIDTH),
        .UV_WIDTH      (UV_WIDTH),
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .JOB_W         (JOB_W),
        .RES_W         (RES_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job_data  (job_rdata),
        .o_job_pop   (job_pop),
        .i_thr       (r_thr),
        .o_res_push  (res_push),
        .o_res_data  (res_wdata),
        .i_res_full  (res_full)
    );

    ttb_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign o_tangent_x   = res_rdata[RES_W-1 -: OW];
    assign o_tangent_y   = res_rdata[RES_W-1-OW -: OW];
    assign o_tangent_z   = res_rdata[RES_W-1-2*OW -: OW];
    assign o_bitangent_x = res_rdata[RES_W-1-3*OW -: OW];
    assign o_bitangent_y = res_rdata[RES_W-1-4*OW -: OW];
    assign o_bitangent_z = res_rdata[RES_W-1-5*OW -: OW];
    assign o_corner      = res_rdata[CORNER_W:1];
    assign o_last        = res_rdata[0];

endmodule
`default_nettype wire
